>>> sv/mpe_pkg.sv
// shared types, constants and helpers for the mandelbrot escape color core
`default_nettype none
package mpe_pkg;

	// fixed point and image limits
	localparam int FRAC_BITS_DEF = 28;
	localparam int MAX_DIM = 4096;

	// divide chain widths: dividend magnitude and divisor
	localparam int DIV_NW = 57;
	localparam int DIV_DW = 16;

	// width of the mapping sums before saturation
	localparam int MAP_W = 59;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_REAL    = 3'd0;
	localparam logic [2:0] REG_MAX_REAL    = 3'd1;
	localparam logic [2:0] REG_MIN_IMAG    = 3'd2;
	localparam logic [2:0] REG_ITER_LIMIT  = 3'd3;
	localparam logic [2:0] REG_IMG_WIDTH   = 3'd4;
	localparam logic [2:0] REG_IMG_HEIGHT  = 3'd5;

	// reset values of the configuration registers
	localparam logic [31:0] MIN_REAL_RST   = 32'hE000_0000;
	localparam logic [31:0] MAX_REAL_RST   = 32'h1000_0000;
	localparam logic [31:0] MIN_IMAG_RST   = 32'hECCC_CCCD;
	localparam logic [15:0] ITER_LIMIT_RST = 16'd256;
	localparam logic [12:0] IMG_WIDTH_RST  = 13'd640;
	localparam logic [12:0] IMG_HEIGHT_RST = 13'd480;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        inside_set;
		logic [15:0] escape_step;
	} pixel_out_t;

	// one stage of the divide chain: quotient and dividend share nq
	typedef struct packed {
		logic              valid;
		logic [DIV_NW-1:0] nq;
		logic [DIV_DW-1:0] rem;
		logic [DIV_DW-1:0] d;
	} div_stage_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RE_REQ,
		ST_RE_WAIT,
		ST_SPAN_REQ,
		ST_SPAN_WAIT,
		ST_IM_REQ,
		ST_IM_WAIT,
		ST_CHECK,
		ST_UPDATE,
		ST_COL_REQ,
		ST_COL_WAIT,
		ST_DONE
	} mpe_state_t;

	// clamp a mapping sum to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [MAP_W-1:0] v);
		logic [31:0] r;
		if (v > $signed(MAP_W'(64'h7FFF_FFFF))) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -$signed(MAP_W'(64'h8000_0000))) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> sv/mandelbrot_pixel_escape_color_core.sv
// Mandelbrot escape-time pixel colorer: top level.
// Input channel in_valid/in_stall/in_data carries one pixel word (column, row).
// Output channel out_valid/out_stall/out_data carries one color word per pixel.
// Configuration: cfg_we writes cfg_data to register cfg_index at a clock edge;
// write only while no pixel is in flight.
// One pixel is worked at a time. It is mapped to a point through three passes of a
// 57-cell divide chain (each pass with an issue and a capture), then each escape loop
// iteration registers the products and then updates, up to the iteration limit; for
// a pixel that escapes, one more chain pass scales the step to a color. The divide
// chain and the escape loop set the latency.
// A new pixel is taken once the previous one has been loaded into the output register,
// even while that result still waits to be taken.
// Reset clears the control state and loads the default view (-2..1, bottom -1.2,
// 256 iterations, 640x480). A stalled output holds its word; the core then waits with
// the next finished pixel until the output register frees.
`default_nettype none
module mandelbrot_pixel_escape_color_core #(
	parameter int FRAC_BITS = mpe_pkg::FRAC_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  mpe_pkg::pixel_in_t      in_data,
	output logic                    out_valid,
	input  wire                     out_stall,
	output mpe_pkg::pixel_out_t     out_data,
	input  wire                     cfg_we,
	input  wire  [2:0]              cfg_index,
	input  wire  [31:0]             cfg_data
);
	import mpe_pkg::*;

	localparam int MW = FRAC_BITS + 2;
	localparam int PW = 2 * MW;
	localparam int ZW = ((FRAC_BITS + 2) > 31 ? (FRAC_BITS + 2) : 31) + 3;
	localparam logic signed [ZW-1:0] TWO_Z  = ZW'(64'd2 << FRAC_BITS);
	localparam logic signed [ZW-1:0] FOUR_Z = ZW'(64'd4 << FRAC_BITS);
	localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

	// configuration registers
	logic signed [31:0] min_real_q, max_real_q, min_imag_q;
	logic [15:0] limit_q;
	logic [12:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_real_q <= MIN_REAL_RST;
			max_real_q <= MAX_REAL_RST;
			min_imag_q <= MIN_IMAG_RST;
			limit_q    <= ITER_LIMIT_RST;
			width_q    <= IMG_WIDTH_RST;
			height_q   <= IMG_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_REAL:   min_real_q <= cfg_data;
				REG_MAX_REAL:   max_real_q <= cfg_data;
				REG_MIN_IMAG:   min_imag_q <= cfg_data;
				REG_ITER_LIMIT: limit_q    <= cfg_data[15:0];
				REG_IMG_WIDTH:  width_q    <= cfg_data[12:0];
				REG_IMG_HEIGHT: height_q   <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// clamped dimensions and real range
	logic [12:0] w_eff, h_eff, hd_eff;
	logic signed [32:0] range_s;
	logic range_neg;
	logic [32:0] range_abs;
	logic [31:0] range_mag;

	always_comb begin
		if (width_q == 13'd0) begin
			w_eff = 13'd1;
		end else if ({19'd0, width_q} > MAX_DIM_W) begin
			w_eff = 13'(MAX_DIM_W);
		end else begin
			w_eff = width_q;
		end
		h_eff = ({19'd0, height_q} > MAX_DIM_W) ? 13'(MAX_DIM_W) : height_q;
		hd_eff = (h_eff >= 13'd2) ? 13'(h_eff - 13'd1) : 13'd1;
		range_s   = 33'(max_real_q) - 33'(min_real_q);
		range_neg = range_s[32];
		range_abs = range_neg ? 33'(-range_s) : range_s;
		range_mag = range_abs[31:0];
	end

	// state and working registers
	mpe_state_t state_q, state_d;
	logic [11:0] px_q, py_q;
	logic [44:0] span_mag_q;
	logic signed [31:0] re_q, im_q;
	logic signed [ZW-1:0] zr_q, zi_q;
	logic [15:0] iter_q;
	logic [PW-1:0] sq_r_q, sq_i_q, cross_q;
	logic cross_neg_q;
	logic inside_q;
	logic [9:0] color_q;
	logic div_req_valid_q;
	logic [DIV_NW-1:0] div_nq_q;
	logic [DIV_DW-1:0] div_d_q;
	div_stage_t div_req, div_rsp;
	pixel_out_t out_q;
	logic out_valid_q;

	assign div_req = {div_req_valid_q, div_nq_q, {DIV_DW{1'b0}}, div_d_q};

	mpe_div_chain u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic in_acc, out_load;
	logic [DIV_NW-1:0] quo;
	logic signed [MAP_W-1:0] quo_s, re_full, span_s, im_full;
	logic escape_box, escape_sum;
	logic signed [ZW-1:0] zr_abs, zi_abs, sr, si, cr, cross_s;
	logic [MW-1:0] zr_m, zi_m;
	logic [9:0] red_w, green_w, blue_w;

	// datapath arithmetic
	always_comb begin
		quo     = div_rsp.nq;
		quo_s   = range_neg ? -$signed(MAP_W'(quo)) : $signed(MAP_W'(quo));
		re_full = $signed(MAP_W'(min_real_q)) + quo_s;
		span_s  = range_neg ? -$signed(MAP_W'(span_mag_q)) : $signed(MAP_W'(span_mag_q));
		im_full = $signed(MAP_W'(min_imag_q)) + span_s - quo_s;

		escape_box = (zr_q > TWO_Z) || (zr_q < -TWO_Z) || (zi_q > TWO_Z) || (zi_q < -TWO_Z);
		zr_abs = zr_q[ZW-1] ? -zr_q : zr_q;
		zi_abs = zi_q[ZW-1] ? -zi_q : zi_q;
		zr_m   = zr_abs[MW-1:0];
		zi_m   = zi_abs[MW-1:0];

		sr      = $signed(ZW'(sq_r_q >> FRAC_BITS));
		si      = $signed(ZW'(sq_i_q >> FRAC_BITS));
		cr      = $signed(ZW'(cross_q >> FRAC_BITS));
		cross_s = cross_neg_q ? -cr : cr;
		escape_sum = (sr + si) > FOUR_Z;

		red_w   = (color_q < 10'd255) ? 10'(10'd255 - color_q) : 10'd0;
		green_w = (color_q > 10'd255) ? 10'(10'd510 - color_q) : 10'd0;
		blue_w  = ((color_q > 10'd127) && (color_q < 10'd382)) ?
			10'(10'd382 - color_q) : 10'd0;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		in_acc   = in_valid && (state_q == ST_IDLE);
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_RE_REQ;
			ST_RE_REQ:    state_d = ST_RE_WAIT;
			ST_RE_WAIT:   if (div_rsp.valid) state_d = ST_SPAN_REQ;
			ST_SPAN_REQ:  state_d = ST_SPAN_WAIT;
			ST_SPAN_WAIT: if (div_rsp.valid) state_d = ST_IM_REQ;
			ST_IM_REQ:    state_d = ST_IM_WAIT;
			ST_IM_WAIT:   if (div_rsp.valid) state_d = ST_CHECK;
			ST_CHECK: begin
				if (iter_q == limit_q) begin
					state_d = ST_DONE;
				end else if (escape_box) begin
					state_d = ST_COL_REQ;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE:    state_d = escape_sum ? ST_COL_REQ : ST_CHECK;
			ST_COL_REQ:   state_d = ST_COL_WAIT;
			ST_COL_WAIT:  if (div_rsp.valid) state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// divide request valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_req_valid_q <= 1'b0;
		end else begin
			div_req_valid_q <= (state_q == ST_RE_REQ) || (state_q == ST_SPAN_REQ) ||
				(state_q == ST_IM_REQ) || (state_q == ST_COL_REQ);
		end
	end

	// divide request operands: product registered before the chain
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RE_REQ: begin
				div_nq_q <= DIV_NW'({32'd0, px_q} * {12'd0, range_mag});
				div_d_q  <= DIV_DW'(w_eff);
			end
			ST_SPAN_REQ: begin
				div_nq_q <= DIV_NW'({13'd0, range_mag} * {32'd0, h_eff});
				div_d_q  <= DIV_DW'(w_eff);
			end
			ST_IM_REQ: begin
				div_nq_q <= DIV_NW'({45'd0, py_q} * {12'd0, span_mag_q});
				div_d_q  <= DIV_DW'(hd_eff);
			end
			default: begin
				div_nq_q <= DIV_NW'({9'd0, iter_q} * 25'd510);
				div_d_q  <= limit_q;
			end
		endcase
	end

	// pixel mapping and escape loop
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= in_data.pixel_x;
			py_q <= in_data.pixel_y;
		end
		case (state_q)
			ST_RE_WAIT:   if (div_rsp.valid) re_q <= sat32(re_full);
			ST_SPAN_WAIT: if (div_rsp.valid) span_mag_q <= quo[44:0];
			ST_IM_WAIT: begin
				if (div_rsp.valid) begin
					im_q   <= sat32(im_full);
					zr_q   <= ZW'(re_q);
					zi_q   <= ZW'($signed(sat32(im_full)));
					iter_q <= '0;
				end
			end
			ST_CHECK: begin
				inside_q    <= (iter_q == limit_q);
				sq_r_q      <= {{MW{1'b0}}, zr_m} * {{MW{1'b0}}, zr_m};
				sq_i_q      <= {{MW{1'b0}}, zi_m} * {{MW{1'b0}}, zi_m};
				cross_q     <= {{MW{1'b0}}, zr_m} * {{MW{1'b0}}, zi_m};
				cross_neg_q <= zr_q[ZW-1] ^ zi_q[ZW-1];
			end
			ST_UPDATE: begin
				if (!escape_sum) begin
					zr_q   <= sr - si + ZW'(re_q);
					zi_q   <= (cross_s <<< 1) + ZW'(im_q);
					iter_q <= 16'(iter_q + 16'd1);
				end
			end
			ST_COL_WAIT:  if (div_rsp.valid) color_q <= quo[9:0];
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.inside_set  <= inside_q;
			out_q.escape_step <= iter_q;
			out_q.red   <= inside_q ? 8'd0 : red_w[7:0];
			out_q.green <= inside_q ? 8'd0 : green_w[7:0];
			out_q.blue  <= inside_q ? 8'd0 : blue_w[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted word did not start work");

	a_div_rsp_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.valid |-> (state_q == ST_RE_WAIT || state_q == ST_SPAN_WAIT ||
			state_q == ST_IM_WAIT || state_q == ST_COL_WAIT))
		else $error("divide result arrived with nobody waiting");

	a_div_req_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		div_req_valid_q |=> !div_req_valid_q)
		else $error("divide request held longer than one cycle");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (iter_q < limit_q))
		else $error("escape loop ran past the iteration limit");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.inside_set) |-> (out_q.red == 8'd0 &&
			out_q.green == 8'd0 && out_q.blue == 8'd0 && out_q.escape_step == limit_q))
		else $error("inside pixel not black or wrong step");
`endif

endmodule
`default_nettype wire

>>> sv/mpe_div_cell.sv
// one restoring divide step: a quotient bit per cell, registered
`default_nettype none
module mpe_div_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  mpe_pkg::div_stage_t     prev,
	output mpe_pkg::div_stage_t     nxt
);
	import mpe_pkg::*;

	logic [DIV_DW:0]   trial;
	logic              ge;
	logic [DIV_DW-1:0] rem_n;
	logic              valid_q;
	logic [DIV_NW-1:0] nq_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] d_q;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {prev.rem, prev.nq[DIV_NW-1]};
		ge    = trial >= {1'b0, prev.d};
		rem_n = ge ? DIV_DW'(trial - {1'b0, prev.d}) : trial[DIV_DW-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		nq_q  <= {prev.nq[DIV_NW-2:0], ge};
		rem_q <= rem_n;
		d_q   <= prev.d;
	end

	assign nxt = {valid_q, nq_q, rem_q, d_q};

endmodule
`default_nettype wire

>>> sv/mpe_div_chain.sv
// row of divide cells, one quotient bit per cell
`default_nettype none
module mpe_div_chain (
	input  wire                     clk,
	input  wire                     arst_n,
	input  mpe_pkg::div_stage_t     req,
	output mpe_pkg::div_stage_t     rsp
);
	import mpe_pkg::*;

	div_stage_t st [DIV_NW+1];

	assign st[0] = req;

	// cells hand the partial remainder to their neighbor each cycle
	for (genvar k = 0; k < DIV_NW; k++) begin : g_cell
		mpe_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (st[k]),
			.nxt    (st[k+1])
		);
	end

	assign rsp = st[DIV_NW];

endmodule
`default_nettype wire

>>> tb/mandelbrot_escape_checker.sv
// checker for the mandelbrot escape color core: watches all ports, predicts and compares words
`timescale 1ns / 100ps
`default_nettype none
module mandelbrot_escape_checker
	import mpe_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  pixel_in_t   in_data,
	input  wire         out_valid,
	input  wire         out_stall,
	input  pixel_out_t  out_data,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam int FRAC = FRAC_BITS_DEF;

	// shadow copy of the view registers
	logic signed [31:0] view_min_re;
	logic signed [31:0] view_max_re;
	logic signed [31:0] view_min_im;
	logic [15:0]        iter_cap;
	logic [12:0]        img_w;
	logic [12:0]        img_h;

	pixel_out_t color_queue[$];

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// fixed point product, truncated toward zero
	function automatic longint fx_mul(input longint a, input longint b);
		longint p;
		longint m;
		p = a * b;
		m = (p < 0) ? -p : p;
		m = m >>> FRAC;
		return (p < 0) ? -m : m;
	endfunction

	// map a pixel to a point, run the escape loop and build the color word
	function automatic pixel_out_t escape_color(input pixel_in_t p);
		longint w, h, hd, rng, span, re, im, zr, zi, sr, si, two, four;
		int unsigned i, color;
		bit escaped;
		pixel_out_t r;
		two = longint'(2) <<< FRAC;
		four = longint'(4) <<< FRAC;
		w = img_w;
		h = img_h;
		if (w < 1) begin
			w = 1;
		end
		if (w > MAX_DIM) begin
			w = MAX_DIM;
		end
		if (h > MAX_DIM) begin
			h = MAX_DIM;
		end
		hd = (h - 1 < 1) ? 1 : h - 1;
		rng = longint'(view_max_re) - longint'(view_min_re);
		re = clamp32(longint'(view_min_re) + (longint'(p.pixel_x) * rng) / w);
		span = (rng * h) / w;
		im = clamp32(longint'(view_min_im) + span - (longint'(p.pixel_y) * span) / hd);
		zr = re;
		zi = im;
		escaped = 1'b0;
		for (i = 0; i < iter_cap; i++) begin
			if (zr > two || zr < -two || zi > two || zi < -two) begin
				escaped = 1'b1;
				break;
			end
			sr = fx_mul(zr, zr);
			si = fx_mul(zi, zi);
			if (sr + si > four) begin
				escaped = 1'b1;
				break;
			end
			zi = 2 * fx_mul(zr, zi) + im;
			zr = sr - si + re;
		end
		r = '0;
		if (!escaped) begin
			r.inside_set = 1'b1;
			r.escape_step = iter_cap;
		end else begin
			color = (i * 510) / iter_cap;
			r.red = (color < 255) ? 8'(255 - color) : 8'd0;
			r.green = (color > 255) ? 8'(510 - color) : 8'd0;
			r.blue = (color > 127 && color < 382) ? 8'(382 - color) : 8'd0;
			r.escape_step = 16'(i);
		end
		return r;
	endfunction

	// track config, queue predictions, compare delivered words
	always @(posedge clk or negedge arst_n) begin
		pixel_out_t want;
		if (!arst_n) begin
			view_min_re <= MIN_REAL_RST;
			view_max_re <= MAX_REAL_RST;
			view_min_im <= MIN_IMAG_RST;
			iter_cap <= ITER_LIMIT_RST;
			img_w <= IMG_WIDTH_RST;
			img_h <= IMG_HEIGHT_RST;
			fail_count <= 0;
			pending <= 0;
			color_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_REAL: view_min_re <= cfg_data;
					REG_MAX_REAL: view_max_re <= cfg_data;
					REG_MIN_IMAG: view_min_im <= cfg_data;
					REG_ITER_LIMIT: iter_cap <= cfg_data[15:0];
					REG_IMG_WIDTH: img_w <= cfg_data[12:0];
					REG_IMG_HEIGHT: img_h <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				color_queue.push_back(escape_color(in_data));
			end
			if (out_valid && !out_stall) begin
				if (color_queue.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected word %h", out_data);
					end
					fail_count <= fail_count + 1;
				end else begin
					want = color_queue.pop_front();
					if (want !== out_data) begin
						if (fail_count < 10) begin
							$display({"mismatch: expected r=%0d g=%0d b=%0d in=%0b step=%0d,",
								" got r=%0d g=%0d b=%0d in=%0b step=%0d"},
								want.red, want.green, want.blue, want.inside_set,
								want.escape_step, out_data.red, out_data.green,
								out_data.blue, out_data.inside_set,
								out_data.escape_step);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= color_queue.size();
		end
	end

endmodule
`default_nettype wire

>>> tb/mandelbrot_pixel_escape_color_core_test.sv
// testbench top for the mandelbrot escape color core: stimulus, config phases and verdict
`timescale 1ns / 100ps
`default_nettype none
module mandelbrot_pixel_escape_color_core_test;
	import mpe_pkg::*;

	localparam int STALL_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	pixel_in_t   in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	pixel_out_t  out_data;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_MIN_REAL;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;
	int          quiet_cycles = 0;
	int          stall_left = 0;
	int unsigned cur_w = 640;

	always #10 clk = ~clk;

	mandelbrot_pixel_escape_color_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mandelbrot_escape_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// random back-pressure on the result side
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (stalls_on && $urandom_range(0, 3) == 0) begin
				stall_left <= gap_len();
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mandelbrot_pixel_escape_color_core_test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_IMG_WIDTH) begin
			cur_w = (val[12:0] == 13'd0) ? 32'd1 :
				((32'(val[12:0]) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(val[12:0]));
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_view(input logic [31:0] mr, input logic [31:0] xr, input logic [31:0] mi,
			input logic [15:0] lim, input logic [12:0] w, input logic [12:0] h);
		write_reg(REG_MIN_REAL, mr);
		write_reg(REG_MAX_REAL, xr);
		write_reg(REG_MIN_IMAG, mi);
		write_reg(REG_ITER_LIMIT, 32'(lim));
		write_reg(REG_IMG_WIDTH, 32'(w));
		write_reg(REG_IMG_HEIGHT, 32'(h));
	endtask

	task automatic drain();
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (5) @(negedge clk);
	endtask

	// present one pixel word and hold it until taken
	task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
		int g;
		g = gaps_on ? gap_len() : 0;
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data.pixel_x = px;
		in_data.pixel_y = py;
		forever begin
			@(posedge clk);
			if (!in_stall) begin
				break;
			end
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	initial begin
		int n;
		int phase;
		int unsigned lo;
		logic [31:0] mr, span_re, mi;
		logic [15:0] lim;
		logic [12:0] w, h;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default view: corners, centre, far outside
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd639, 12'd479);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd427, 12'd240);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		// hold off until the core is empty
		drain();
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd213, 12'd100);
		drain();

		// zero iteration limit
		set_view(32'hE000_0000, 32'h1000_0000, 32'hECCC_CCCD, 16'd0, 13'd640, 13'd480);
		send_pixel(12'd10, 12'd20);
		send_pixel(12'd4095, 12'd4095);
		drain();

		// zero width and height below two
		set_view(32'hE000_0000, 32'h1000_0000, 32'hECCC_CCCD, 16'd40, 13'd0, 13'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		drain();
		write_reg(REG_IMG_HEIGHT, 32'd1);
		write_reg(REG_IMG_WIDTH, 32'd8191);
		send_pixel(12'd2048, 12'd0);
		send_pixel(12'd3000, 12'd4095);
		drain();

		// extreme bounds with saturation, full iteration limit
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 13'd1, 13'd2);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		drain();
		// zero range: the origin never escapes
		set_view(32'h0, 32'h0, 32'h0, 16'hFFFF, 13'd8191, 13'd8191);
		send_pixel(12'd5, 12'd7);
		drain();

		// random phases
		n = 0;
		phase = 0;
		while (n < 1430) begin
			gaps_on = (phase % 4) != 2;
			stalls_on = (phase % 5) != 3;
			if ($urandom_range(0, 4) == 0) begin
				mr = $urandom;
				span_re = $urandom;
				mi = $urandom;
				lim = 16'($urandom_range(1, 1000));
			end else begin
				mr = 32'($urandom_range(0, 3 << 28)) - 32'(5 << 27);
				span_re = $urandom_range(1 << 20, 3 << 28);
				mi = -32'($urandom_range(0, 3 << 27));
				lim = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(100, 400))
					: 16'($urandom_range(1, 100));
			end
			if ($urandom_range(0, 3) == 0) begin
				w = 13'($urandom);
				h = 13'($urandom);
			end else begin
				w = 13'($urandom_range(1, 800));
				h = 13'($urandom_range(2, 600));
			end
			set_view(mr, mr + span_re, mi, lim, w, h);
			repeat ($urandom_range(60, 130)) begin
				if ($urandom_range(0, 4) == 0) begin
					send_pixel(12'($urandom), 12'($urandom));
				end else begin
					lo = (h == 13'd0) ? 32'd1 :
						((32'(h) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(h));
					send_pixel(12'($urandom_range(0, cur_w - 1)),
						12'($urandom_range(0, lo - 1)));
				end
				n++;
			end
			drain();
			phase++;
		end

		// final drain with settle time
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (300) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("mandelbrot_pixel_escape_color_core_test passed");
		end else begin
			$display("mandelbrot_pixel_escape_color_core_test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> mandelbrot_pixel_escape_color_core.f
sv/mpe_pkg.sv
sv/mpe_div_cell.sv
sv/mpe_div_chain.sv
sv/mandelbrot_pixel_escape_color_core.sv
tb/mandelbrot_escape_checker.sv
tb/mandelbrot_pixel_escape_color_core_test.sv
